FILE: hdl/drd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// drd_pkg
// Shared types and constants for the delta record deframer.
// ----------------------------------------------------------------------------
package drd_pkg;

  localparam int unsigned ApbAddrWidth = 3;
  localparam int unsigned ApbDataWidth = 32;

  localparam logic [7:0] VersionCode = 8'h01;
  localparam int unsigned TsBytes  = 8;
  localparam int unsigned CtrBytes = 4;
  localparam int unsigned CountBytes = 4;

  localparam logic [2:0] KindKey      = 3'd0;
  localparam logic [2:0] KindVal      = 3'd1;
  localparam logic [2:0] KindRecord   = 3'd2;
  localparam logic [2:0] KindStream   = 3'd3;
  localparam logic [2:0] KindUnderrun = 3'd4;
  localparam logic [2:0] KindBadVer   = 3'd5;

  // register index of stream_mode
  localparam logic RegStreamMode = 1'b0;

  localparam int unsigned ResultDepth = 4;
  localparam int unsigned PtrWidth    = $clog2(ResultDepth);
  localparam int unsigned CountWidth  = $clog2(ResultDepth + 1);

  typedef enum logic [3:0] {
    PH_START,
    PH_COUNT,
    PH_VERSION,
    PH_KLEN_LO,
    PH_KLEN_HI,
    PH_KEY,
    PH_VLEN_LO,
    PH_VLEN_HI,
    PH_VAL,
    PH_TS,
    PH_CTR,
    PH_DONE,
    PH_ERROR
  } phase_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  payload;
    logic [63:0] timestamp;
    logic [31:0] counter;
    logic        last;
  } result_t;

  // results produced by one accepted byte, in order
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

endpackage
`default_nettype wire

FILE: hdl/drd_byte_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// drd_byte_if
// Valid/ready channel carrying one buffer byte and its end flag.
// ----------------------------------------------------------------------------
interface drd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_buffer;

  modport source (output valid, output data_byte, output end_of_buffer, input ready);
  modport sink   (input valid, input data_byte, input end_of_buffer, output ready);
endinterface
`default_nettype wire

FILE: hdl/drd_result_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// drd_result_if
// Valid/ready channel carrying one parse result.
// ----------------------------------------------------------------------------
interface drd_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  result_kind;
  logic [7:0]  payload_byte;
  logic [63:0] record_timestamp;
  logic [31:0] record_counter;
  logic        last_of_run;

  modport source (output valid, output result_kind, output payload_byte,
                  output record_timestamp, output record_counter,
                  output last_of_run, input ready);
  modport sink   (input valid, input result_kind, input payload_byte,
                  input record_timestamp, input record_counter,
                  input last_of_run, output ready);
endinterface
`default_nettype wire

FILE: hdl/delta_record_deframer.sv
`timescale 1ns / 1ps
`default_nettype none
// Results: a result enters the queue as the byte that causes it is accepted, and is offered in order.
// Throughput: one byte per cycle while the queue has room for two results; a byte
// giving two results (record end plus stream end, or any result plus underrun)
// takes two output transactions; the port moves one a cycle out of a four-entry queue.
// Reset (rst, synchronous): parser idle awaiting a new stream, queue empty,
// stream_mode 0. A byte flagged end_of_buffer also returns the parser to idle.
// ----------------------------------------------------------------------------
// delta_record_deframer
// Byte-serial parser for little-endian key/value delta records.
// ----------------------------------------------------------------------------
module delta_record_deframer (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [drd_pkg::ApbAddrWidth-1:0]  paddr,
  input  wire logic [drd_pkg::ApbDataWidth-1:0]  pwdata,
  output logic      [drd_pkg::ApbDataWidth-1:0]  prdata,
  output logic                                   pready,
  drd_byte_if.sink                               byte_ch,
  drd_result_if.source                           result_ch
);

  logic             stream_mode;
  logic             accept;
  logic             space;
  drd_pkg::push_t   push;
  drd_pkg::result_t head;

  drd_apb_regs u_regs (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .stream_mode (stream_mode)
  );

  assign byte_ch.ready = space;
  assign accept        = byte_ch.valid && space;

  drd_parser u_parser (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .data_byte     (byte_ch.data_byte),
    .end_of_buffer (byte_ch.end_of_buffer),
    .stream_mode   (stream_mode),
    .push          (push)
  );

  drd_result_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .space (space),
    .valid (result_ch.valid),
    .ready (result_ch.ready),
    .head  (head)
  );

  assign result_ch.result_kind      = head.kind;
  assign result_ch.payload_byte     = head.payload;
  assign result_ch.record_timestamp = head.timestamp;
  assign result_ch.record_counter   = head.counter;
  assign result_ch.last_of_run      = head.last;

endmodule
`default_nettype wire

FILE: hdl/drd_apb_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// drd_apb_regs
// APB register slave holding the stream mode.
// ----------------------------------------------------------------------------
module drd_apb_regs (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [drd_pkg::ApbAddrWidth-1:0]  paddr,
  input  wire logic [drd_pkg::ApbDataWidth-1:0]  pwdata,
  output logic      [drd_pkg::ApbDataWidth-1:0]  prdata,
  output logic                                   pready,
  output logic                                   stream_mode
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stream_mode <= 1'b0;
    end else if (wr_en && (paddr[2] == drd_pkg::RegStreamMode)) begin
      stream_mode <= pwdata[0];
    end
  end

  always_comb begin
    unique case (paddr[2])
      drd_pkg::RegStreamMode: prdata = {{(drd_pkg::ApbDataWidth-1){1'b0}}, stream_mode};
      default:                prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

FILE: hdl/drd_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// drd_parser
// Record parse state machine; turns each accepted byte into up to two results.
// ----------------------------------------------------------------------------
module drd_parser (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         accept,
  input  wire logic [7:0]   data_byte,
  input  wire logic         end_of_buffer,
  input  wire logic         stream_mode,
  output drd_pkg::push_t    push
);

  drd_pkg::phase_t phase, phase_e, phase_parsed;
  logic [15:0] remaining, rem_parsed, rem_dec, len_full;
  logic [7:0]  len_low, low_parsed;
  logic [2:0]  idx, idx_e, idx_parsed, idx_inc;
  logic [63:0] ts_acc, ts_parsed, ts_new;
  logic [31:0] ctr_acc, ctr_parsed, ctr_new;
  logic [31:0] records_left, rec_e, rec_parsed, rec_new, rec_dec;
  logic        underrun;

  drd_pkg::result_t p0, p1;
  logic [1:0]       prim_n;

  function automatic drd_pkg::result_t mk(input logic [2:0]  kind,
                                          input logic [7:0]  payload,
                                          input logic [63:0] ts,
                                          input logic [31:0] ctr);
    drd_pkg::result_t r;
    r.kind      = kind;
    r.payload   = payload;
    r.timestamp = ts;
    r.counter   = ctr;
    r.last      = 1'b0;
    return r;
  endfunction

  // first byte of a stream latches the mode
  always_comb begin
    phase_e = phase;
    idx_e   = idx;
    rec_e   = records_left;
    if (phase == drd_pkg::PH_START) begin
      idx_e   = '0;
      rec_e   = stream_mode ? 32'd0 : 32'd1;
      phase_e = stream_mode ? drd_pkg::PH_COUNT : drd_pkg::PH_VERSION;
    end
  end

  assign idx_inc  = idx_e + 3'd1;
  assign rec_new  = rec_e | (32'(data_byte) << {idx_e[1:0], 3'b000});
  assign ts_new   = ts_acc | (64'(data_byte) << {idx_e, 3'b000});
  assign ctr_new  = ctr_acc | (32'(data_byte) << {idx_e[1:0], 3'b000});
  assign rec_dec  = rec_e - 32'd1;
  assign rem_dec  = remaining - 16'd1;
  assign len_full = {data_byte, len_low};

  // next state
  always_comb begin
    phase_parsed = phase_e;
    idx_parsed   = idx_e;
    rec_parsed   = rec_e;
    rem_parsed   = remaining;
    low_parsed   = len_low;
    ts_parsed    = ts_acc;
    ctr_parsed   = ctr_acc;
    unique case (phase_e)
      drd_pkg::PH_COUNT: begin
        rec_parsed = rec_new;
        idx_parsed = idx_inc;
        if (idx_e == 3'(drd_pkg::CountBytes - 1)) begin
          idx_parsed   = '0;
          phase_parsed = (rec_new == 32'd0) ? drd_pkg::PH_DONE : drd_pkg::PH_VERSION;
        end
      end
      drd_pkg::PH_VERSION: begin
        phase_parsed = (data_byte != drd_pkg::VersionCode) ? drd_pkg::PH_ERROR
                                                            : drd_pkg::PH_KLEN_LO;
      end
      drd_pkg::PH_KLEN_LO, drd_pkg::PH_VLEN_LO: begin
        low_parsed   = data_byte;
        phase_parsed = (phase_e == drd_pkg::PH_KLEN_LO) ? drd_pkg::PH_KLEN_HI
                                                          : drd_pkg::PH_VLEN_HI;
      end
      drd_pkg::PH_KLEN_HI: begin
        rem_parsed   = len_full;
        phase_parsed = (len_full != 16'd0) ? drd_pkg::PH_KEY : drd_pkg::PH_VLEN_LO;
      end
      drd_pkg::PH_KEY: begin
        rem_parsed = rem_dec;
        if (rem_dec == 16'd0) begin
          phase_parsed = drd_pkg::PH_VLEN_LO;
        end
      end
      drd_pkg::PH_VLEN_HI: begin
        rem_parsed = len_full;
        if (len_full != 16'd0) begin
          phase_parsed = drd_pkg::PH_VAL;
        end else begin
          phase_parsed = drd_pkg::PH_TS;
          idx_parsed   = '0;
          ts_parsed    = '0;
          ctr_parsed   = '0;
        end
      end
      drd_pkg::PH_VAL: begin
        rem_parsed = rem_dec;
        if (rem_dec == 16'd0) begin
          phase_parsed = drd_pkg::PH_TS;
          idx_parsed   = '0;
          ts_parsed    = '0;
          ctr_parsed   = '0;
        end
      end
      drd_pkg::PH_TS: begin
        ts_parsed  = ts_new;
        idx_parsed = idx_inc;
        if (idx_e == 3'(drd_pkg::TsBytes - 1)) begin
          idx_parsed   = '0;
          phase_parsed = drd_pkg::PH_CTR;
        end
      end
      drd_pkg::PH_CTR: begin
        ctr_parsed = ctr_new;
        idx_parsed = idx_inc;
        if (idx_e == 3'(drd_pkg::CtrBytes - 1)) begin
          idx_parsed   = '0;
          rec_parsed   = rec_dec;
          phase_parsed = (rec_dec == 32'd0) ? drd_pkg::PH_DONE : drd_pkg::PH_VERSION;
        end
      end
      default: begin
      end
    endcase
  end

  assign underrun = end_of_buffer && (phase_parsed != drd_pkg::PH_DONE)
                    && (phase_parsed != drd_pkg::PH_ERROR);

  // results
  always_comb begin
    p0     = mk(drd_pkg::KindKey, 8'd0, 64'd0, 32'd0);
    p1     = p0;
    prim_n = 2'd0;
    unique case (phase_e)
      drd_pkg::PH_KEY: begin
        p0     = mk(drd_pkg::KindKey, data_byte, 64'd0, 32'd0);
        prim_n = 2'd1;
      end
      drd_pkg::PH_VAL: begin
        p0     = mk(drd_pkg::KindVal, data_byte, 64'd0, 32'd0);
        prim_n = 2'd1;
      end
      drd_pkg::PH_VERSION: begin
        if (data_byte != drd_pkg::VersionCode) begin
          p0     = mk(drd_pkg::KindBadVer, 8'd0, 64'd0, 32'd0);
          prim_n = 2'd1;
        end
      end
      drd_pkg::PH_COUNT: begin
        if ((idx_e == 3'(drd_pkg::CountBytes - 1)) && (rec_new == 32'd0)) begin
          p0     = mk(drd_pkg::KindStream, 8'd0, 64'd0, 32'd0);
          prim_n = 2'd1;
        end
      end
      drd_pkg::PH_CTR: begin
        if (idx_e == 3'(drd_pkg::CtrBytes - 1)) begin
          p0     = mk(drd_pkg::KindRecord, 8'd0, ts_acc, ctr_new);
          prim_n = 2'd1;
          if (rec_dec == 32'd0) begin
            p1     = mk(drd_pkg::KindStream, 8'd0, 64'd0, 32'd0);
            prim_n = 2'd2;
          end
        end
      end
      default: begin
      end
    endcase

    push.first  = p0;
    push.second = p1;
    push.count  = prim_n;
    // underrun trails whatever this byte gave; never a third result
    if (underrun) begin
      if (prim_n == 2'd0) begin
        push.first = mk(drd_pkg::KindUnderrun, 8'd0, 64'd0, 32'd0);
        push.count = 2'd1;
      end else begin
        push.second = mk(drd_pkg::KindUnderrun, 8'd0, 64'd0, 32'd0);
        push.count  = 2'd2;
      end
    end
    if (push.count == 2'd2) begin
      push.second.last = 1'b1;
    end else begin
      push.first.last = 1'b1;
    end
    if (!accept) begin
      push.count = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && end_of_buffer)) begin
      phase        <= drd_pkg::PH_START;
      remaining    <= '0;
      len_low      <= '0;
      idx          <= '0;
      ts_acc       <= '0;
      ctr_acc      <= '0;
      records_left <= '0;
    end else if (accept) begin
      phase        <= phase_parsed;
      remaining    <= rem_parsed;
      len_low      <= low_parsed;
      idx          <= idx_parsed;
      ts_acc       <= ts_parsed;
      ctr_acc      <= ctr_parsed;
      records_left <= rec_parsed;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/drd_result_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// drd_result_fifo
// Small result queue: takes up to two results a cycle, gives one a cycle.
// ----------------------------------------------------------------------------
module drd_result_fifo (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire drd_pkg::push_t     push,
  output logic                    space,
  output logic                    valid,
  input  wire logic               ready,
  output drd_pkg::result_t        head
);

  drd_pkg::result_t entries [drd_pkg::ResultDepth];
  logic [drd_pkg::PtrWidth-1:0]   wr_ptr, rd_ptr, wr_ptr_next, rd_ptr_next;
  logic [drd_pkg::CountWidth-1:0] count, count_next;
  logic                           pop;

  // room for a worst-case byte (two results)
  assign space = count <= drd_pkg::CountWidth'(drd_pkg::ResultDepth - 2);
  assign valid = count != '0;
  assign pop   = valid && ready;
  assign head  = entries[rd_ptr];

  assign wr_ptr_next = wr_ptr + drd_pkg::PtrWidth'(push.count);
  assign rd_ptr_next = rd_ptr + drd_pkg::PtrWidth'(pop);
  assign count_next  = count + drd_pkg::CountWidth'(push.count)
                       - drd_pkg::CountWidth'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      entries[wr_ptr + drd_pkg::PtrWidth'(1)] <= push.second;
    end
  end

endmodule
`default_nettype wire
